>>> rtl/rmf_pkg.sv
// Shared types and constants for the running median filter.
`timescale 1ns / 1ps

package rmf_pkg;

    // Width of one sample and of one median result.
    localparam int SAMPLE_W = 16;

    typedef logic [SAMPLE_W-1:0] t_sample;

    // Flags that one cell shows to its neighbors in the sorted chain.
    typedef struct packed {
        logic vld;  // cell holds a sample
        logic ge;   // held sample is greater than or equal to the new sample
    } t_link;

endpackage

>>> rtl/rmf_cell.sv
// One cell of the sorted chain: holds a sample and its age, and shifts on each insert.
`timescale 1ns / 1ps

module rmf_cell
    import rmf_pkg::*;
#(
    parameter int WINDOW = 13,
    parameter int AGE_W  = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  t_sample          i_sample,
    input  logic             i_full,
    input  t_link            i_up,
    input  logic             i_up_del,
    input  t_sample          i_up_val,
    input  logic [AGE_W-1:0] i_up_age,
    input  t_link            i_dn,
    input  t_sample          i_dn_val,
    input  logic [AGE_W-1:0] i_dn_age,
    output t_link            o_link,
    output logic             o_del,
    output t_sample          o_val,
    output logic [AGE_W-1:0] o_age,
    output t_sample          o_next_val,
    output logic             o_next_vld
);

    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(WINDOW - 1);

    logic             r_vld;
    t_sample          r_val;
    logic [AGE_W-1:0] r_age;
    logic             n_vld;
    t_sample          n_val;
    logic [AGE_W-1:0] n_age;

    logic             ge_own;
    logic             del_own;
    logic             del_here;
    // Entry at this position once the evicted entry is taken out.
    logic             rm_vld;
    logic             rm_ge;
    t_sample          rm_val;
    logic [AGE_W-1:0] rm_age;
    // Entry one position up once the evicted entry is taken out.
    logic             rmu_vld;
    logic             rmu_ge;
    t_sample          rmu_val;
    logic [AGE_W-1:0] rmu_age;

    // Compare against the new sample and find the entry to evict: the oldest
    // entry when full, otherwise the first empty cell.
    always_comb begin
        ge_own   = r_vld && (r_val >= i_sample);
        del_own  = i_full ? (r_vld && (r_age == AGE_MAX)) : (!r_vld && i_up.vld);
        del_here = i_up_del | del_own;
    end

    // Close the gap left by the evicted entry.
    always_comb begin
        if (!del_here) begin
            rm_vld = r_vld;
            rm_ge  = ge_own;
            rm_val = r_val;
            rm_age = r_age;
        end else begin
            rm_vld = i_dn.vld;
            rm_ge  = i_dn.ge;
            rm_val = i_dn_val;
            rm_age = i_dn_age;
        end
        if (!i_up_del) begin
            rmu_vld = i_up.vld;
            rmu_ge  = i_up.ge;
            rmu_val = i_up_val;
            rmu_age = i_up_age;
        end else begin
            rmu_vld = r_vld;
            rmu_ge  = ge_own;
            rmu_val = r_val;
            rmu_age = r_age;
        end
    end

    // Keep the entry above the insertion point, take the new sample at it,
    // and shift down below it. Held entries grow one step older.
    always_comb begin
        if (rm_ge) begin
            n_vld = rm_vld;
            n_val = rm_val;
            n_age = (rm_age == AGE_MAX) ? rm_age : rm_age + 1'b1;
        end else if (rmu_ge) begin
            n_vld = 1'b1;
            n_val = i_sample;
            n_age = '0;
        end else begin
            n_vld = rmu_vld;
            n_val = rmu_val;
            n_age = (rmu_age == AGE_MAX) ? rmu_age : rmu_age + 1'b1;
        end
    end

    // Occupancy flag is control state and is cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= n_vld;
        end
    end

    // Sample and age need no reset; they count only while the cell is occupied.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_val <= n_val;
            r_age <= n_age;
        end
    end

    assign o_link     = '{vld: r_vld, ge: ge_own};
    assign o_del      = del_here;
    assign o_val      = r_val;
    assign o_age      = r_age;
    assign o_next_val = n_val;
    assign o_next_vld = n_vld;

endmodule

>>> rtl/running_median_filter_top.sv
// Running median filter top level: sorted insertion chain and output register.
// The median of a sample is shown in the cycle after its transfer is accepted.
// Throughput: one sample per cycle unless stalled; the chain inserts and evicts in the same cycle.
// The output register holds one result; input stalls only while it is full and stalled.
// Reset (synchronous, active low) empties the window and clears the output valid.
`timescale 1ns / 1ps

module running_median_filter_top
    import rmf_pkg::*;
#(
    parameter int WINDOW = 13
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [15:0]   i_sample,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [15:0]   o_median
);

    localparam int AGE_W = $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);

    logic             accept;
    t_sample          sample_adj;
    logic             full;
    logic [CNT_W-1:0] r_count;
    logic [AGE_W-1:0] med_idx;
    t_sample          med_next;
    logic             r_out_vld;
    t_sample          r_median;

    // Neighbor buses; index 0 and WINDOW+1 are the chain ends.
    t_link            w_link [WINDOW+2];
    t_sample          w_val  [WINDOW+2];
    logic [AGE_W-1:0] w_age  [WINDOW+2];
    logic             w_del  [WINDOW+1];
    t_sample          w_nval [WINDOW];
    logic [WINDOW-1:0] w_nvld;
    logic [WINDOW-1:0] cur_vld;

    // Transfer control: one output register parts the two sides.
    assign o_stall = r_out_vld && i_stall;
    assign accept  = i_valid && !o_stall;

    // Zero is reserved as the empty marker, so it is ranked as one.
    assign sample_adj = (i_sample == '0) ? t_sample'(1) : i_sample;
    assign full       = (r_count == CNT_W'(WINDOW));

    // Chain ends: above the first cell everything ranks higher, below the last nothing.
    assign w_link[0]        = '{vld: 1'b1, ge: 1'b1};
    assign w_val[0]         = '0;
    assign w_age[0]         = '0;
    assign w_del[0]         = 1'b0;
    assign w_link[WINDOW+1] = '{vld: 1'b0, ge: 1'b0};
    assign w_val[WINDOW+1]  = '0;
    assign w_age[WINDOW+1]  = '0;

    // Row of cells, largest sample first.
    for (genvar gi = 0; gi < WINDOW; gi++) begin : g_cell
        rmf_cell #(
            .WINDOW(WINDOW),
            .AGE_W (AGE_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_load    (accept),
            .i_sample  (sample_adj),
            .i_full    (full),
            .i_up      (w_link[gi]),
            .i_up_del  (w_del[gi]),
            .i_up_val  (w_val[gi]),
            .i_up_age  (w_age[gi]),
            .i_dn      (w_link[gi+2]),
            .i_dn_val  (w_val[gi+2]),
            .i_dn_age  (w_age[gi+2]),
            .o_link    (w_link[gi+1]),
            .o_del     (w_del[gi+1]),
            .o_val     (w_val[gi+1]),
            .o_age     (w_age[gi+1]),
            .o_next_val(w_nval[gi]),
            .o_next_vld(w_nvld[gi])
        );
        assign cur_vld[gi] = w_link[gi+1].vld;
    end

    // Number of samples held, saturating at the window length.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (accept && !full) begin
            r_count <= r_count + 1'b1;
        end
    end

    // Median position after the insert: index (n-1)/2 with n samples held.
    assign med_idx  = full ? AGE_W'((WINDOW - 1) / 2) : AGE_W'(r_count >> 1);
    assign med_next = w_nval[med_idx];

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (accept) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_median <= med_next;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_median = r_median;

    // Every accepted sample leaves a result in the output register.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("accepted sample left no result");

    // A median is never the empty marker.
    a_median_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_median != '0))
        else $error("median is zero");

    // Occupied cells match the fill count.
    a_fill_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(cur_vld) == int'(r_count))
        else $error("occupied cells disagree with fill count");

    // The cell chosen for the median is occupied after the insert.
    a_median_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> w_nvld[med_idx])
        else $error("median taken from an empty cell");

endmodule

>>> sim/tb_running_median_filter_top.sv
// Self-checking testbench for the running median filter top level.
`timescale 1ns / 1ps

module tb_running_median_filter_top
    import rmf_pkg::*;
();

    localparam int WIN         = 13;
    localparam int CLK_HALF    = 10;
    localparam int RST_CYCLES  = 10;
    localparam int STALL_LIMIT = 2000;
    localparam int N_DIRECTED  = 23;
    localparam int N_PHASE     = 3;

    // Stimulus row: a sample and, where it is obvious, the median it must give.
    typedef struct {
        t_sample smp;
        bit      typed;
        t_sample med;
    } t_row;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    i_valid;
    logic    o_stall;
    t_sample i_sample;
    logic    o_valid;
    logic    i_stall = 1'b0;
    t_sample o_median;

    // Typed expectation that travels with the sample being offered.
    bit      drv_typed;
    t_sample drv_typed_med;

    // Idle rates in percent for the two sides.
    int send_idle;
    int recv_idle;

    // Window copy used to predict medians.
    t_sample    win_val [WIN];
    logic [5:0] win_age [WIN];
    logic [5:0] win_fill;

    t_sample median_q [$];
    t_sample want_med;
    t_sample pred_med;
    t_sample ramp_val;
    int      n_errors;
    int      n_sent;
    int      n_checked;
    int      quiet_cycles;

    t_row dir_tab [N_DIRECTED];
    int   phase_items [N_PHASE];
    int   phase_send  [N_PHASE];
    int   phase_recv  [N_PHASE];

    running_median_filter_top #(
        .WINDOW (WIN)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_sample (i_sample),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_median (o_median)
    );

    // Free-running clock.
    always #(CLK_HALF) i_clk = ~i_clk;

    // Inserts one sample into the window copy and returns the new median.
    function automatic t_sample median_insert(input t_sample raw);
        t_sample s;
        t_sample sorted [WIN];
        t_sample tmp;
        int      slot;
        int      held;
        int      i;
        int      j;
        s    = (raw == '0) ? t_sample'(1) : raw;
        slot = 0;
        if (win_fill < WIN) begin
            slot     = win_fill;
            win_fill = win_fill + 1'b1;
        end else begin
            for (i = 0; i < WIN; i++) begin
                if (win_age[i] == 6'(WIN - 1)) begin
                    slot = i;
                    break;
                end
            end
        end
        held = win_fill;
        for (i = 0; i < held; i++) begin
            if (win_age[i] < 6'(WIN - 1)) begin
                win_age[i] = win_age[i] + 1'b1;
            end
        end
        win_val[slot] = s;
        win_age[slot] = '0;
        // Sort the held entries in descending order and take position ceil(n/2).
        for (i = 0; i < held; i++) begin
            sorted[i] = win_val[i];
        end
        for (i = 1; i < held; i++) begin
            tmp = sorted[i];
            j   = i - 1;
            while (j >= 0 && sorted[j] < tmp) begin
                sorted[j + 1] = sorted[j];
                j--;
            end
            sorted[j + 1] = tmp;
        end
        return sorted[(held + 1) / 2 - 1];
    endfunction

    // Random sample with a bias toward extremes, ties and slow ramps.
    function automatic t_sample pick_sample();
        t_sample v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = t_sample'($urandom);
            4:          v = t_sample'($urandom_range(0, 3));
            5: begin
                case ($urandom_range(0, 3))
                    0:       v = 16'h0000;
                    1:       v = 16'h0001;
                    2:       v = 16'hFFFE;
                    default: v = 16'hFFFF;
                endcase
            end
            6, 7:       v = t_sample'($urandom_range(0, 4) * 16'h1111);
            default: begin
                ramp_val = ramp_val + t_sample'($urandom_range(0, 300)) - 16'd150;
                v        = ramp_val;
            end
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string what, input t_sample got, input t_sample want);
        n_errors++;
        $display("MISMATCH @%0t: %s, got %h, want %h", $time, what, got, want);
    endtask

    // Offers one sample from a falling edge and returns at the falling edge after its transfer.
    task automatic send_sample(input t_sample smp, input bit typed, input t_sample med);
        while ($urandom_range(0, 99) < send_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_sample      <= smp;
        drv_typed     <= typed;
        drv_typed_med <= med;
        do begin
            @(posedge i_clk);
        end while (!(i_valid && !o_stall));
        @(negedge i_clk);
    endtask

    // Receiver stalls at random, changed on the falling edge.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_idle);
    end

    // Monitor: checks each result transfer and predicts each accepted sample.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (median_q.size() == 0) begin
                    report_mismatch("result with nothing pending", o_median, '0);
                end else begin
                    want_med = median_q.pop_front();
                    n_checked++;
                    if (o_median !== want_med) begin
                        report_mismatch("median", o_median, want_med);
                    end
                end
            end
            if (i_valid && !o_stall) begin
                pred_med = median_insert(i_sample);
                median_q.insert(median_q.size(), drv_typed ? drv_typed_med : pred_med);
                n_sent++;
            end
            if ((o_valid && !i_stall) || (i_valid && !o_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
    end

    // Watchdog on cycles without any transfer.
    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("** running_median_filter_top: FAILED **");
        $finish;
    end

    // Directed rows: extremes, zero as one, ties, filling and then wrapping the window.
    initial begin
        dir_tab[0]  = '{16'h0000, 1'b1, 16'h0001};
        dir_tab[1]  = '{16'hFFFF, 1'b1, 16'hFFFF};
        dir_tab[2]  = '{16'h0000, 1'b1, 16'h0001};
        dir_tab[3]  = '{16'hFFFF, 1'b1, 16'hFFFF};
        dir_tab[4]  = '{16'h0001, 1'b1, 16'h0001};
        dir_tab[5]  = '{16'h8000, 1'b0, 16'h0000};
        dir_tab[6]  = '{16'h4000, 1'b0, 16'h0000};
        dir_tab[7]  = '{16'h5555, 1'b0, 16'h0000};
        dir_tab[8]  = '{16'hAAAA, 1'b0, 16'h0000};
        dir_tab[9]  = '{16'd100,  1'b0, 16'h0000};
        dir_tab[10] = '{16'd100,  1'b0, 16'h0000};
        dir_tab[11] = '{16'd100,  1'b0, 16'h0000};
        dir_tab[12] = '{16'd100,  1'b0, 16'h0000};
        dir_tab[13] = '{16'hFFFF, 1'b0, 16'h0000};
        dir_tab[14] = '{16'h0000, 1'b0, 16'h0000};
        dir_tab[15] = '{16'd200,  1'b0, 16'h0000};
        dir_tab[16] = '{16'd300,  1'b0, 16'h0000};
        dir_tab[17] = '{16'd400,  1'b0, 16'h0000};
        dir_tab[18] = '{16'h0001, 1'b0, 16'h0000};
        dir_tab[19] = '{16'h0002, 1'b0, 16'h0000};
        dir_tab[20] = '{16'hFFFE, 1'b0, 16'h0000};
        dir_tab[21] = '{16'h00FF, 1'b0, 16'h0000};
        dir_tab[22] = '{16'hFF00, 1'b0, 16'h0000};
    end

    // Main sequence: reset, directed rows, three random phases, drain and verdict.
    initial begin
        int p;
        int k;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_sample      = '0;
        drv_typed     = 1'b0;
        drv_typed_med = '0;
        n_errors      = 0;
        n_sent        = 0;
        n_checked     = 0;
        quiet_cycles  = 0;
        ramp_val      = 16'h8000;
        win_fill      = '0;
        for (k = 0; k < WIN; k++) begin
            win_val[k] = '0;
            win_age[k] = '0;
        end
        phase_items = '{600, 600, 527};
        phase_send  = '{26, 68, 0};
        phase_recv  = '{68, 26, 0};
        send_idle   = phase_send[0];
        recv_idle   = phase_recv[0];

        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (k = 0; k < N_DIRECTED; k++) begin
            send_sample(dir_tab[k].smp, dir_tab[k].typed, dir_tab[k].med);
        end

        for (p = 0; p < N_PHASE; p++) begin
            send_idle = phase_send[p];
            recv_idle = phase_recv[p];
            for (k = 0; k < phase_items[p]; k++) begin
                send_sample(pick_sample(), 1'b0, '0);
            end
        end
        i_valid <= 1'b0;

        // Drain the pending medians; the watchdog bounds this wait.
        while (median_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (5) @(posedge i_clk);
        if (median_q.size() != 0) begin
            report_mismatch("median still pending at end", '0, median_q[0]);
        end

        $display("Summary: %0d samples sent, %0d medians checked, %0d mismatches.",
                 n_sent, n_checked, n_errors);
        $display("Covered: directed extremes and ties, window fill and wrap, three idle mixes.");
        if (n_errors == 0) begin
            $display("** running_median_filter_top: PASSED **");
        end else begin
            $display("** running_median_filter_top: FAILED **");
        end
        $finish;
    end

endmodule
